### rtl/bba_pkg.sv
// bba_pkg: shared constants, word types and sequencer states of the bitmap block allocator
// no dependencies
`default_nettype none

package bba_pkg;

  // defaults for the top-level parameters
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int WORD_BITS_DEF  = 32;

  // fixed field widths
  localparam int NUM_W    = 10;
  localparam int STATUS_W = 2;

  // fixed-point shift used for the reciprocal divide of a block number by the word size
  localparam int RECIP_SH = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  typedef struct packed {
    logic             kind;
    logic [NUM_W-1:0] block_number;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    granted_block;
  } out_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALOC_SCAN,
    S_FREE_DIV,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } seq_state_e;

endpackage

`default_nettype wire

### rtl/bba_bitmap_mem.sv
// bba_bitmap_mem: usage bitmap storage, one write port and one registered read port
// depends on bba_pkg
`default_nettype none

module bba_bitmap_mem
  import bba_pkg::*;
#(
  parameter int NumBlocks  = NUM_BLOCKS_DEF,
  parameter int WordBits   = WORD_BITS_DEF,
  localparam int NumWords  = (NumBlocks + WordBits - 1) / WordBits,
  localparam int WaW       = (NumWords > 1) ? $clog2(NumWords) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [WaW-1:0]      waddr_i,
  input  wire logic [WordBits-1:0] wdata_i,
  input  wire logic [WaW-1:0]      raddr_i,
  output logic      [WordBits-1:0] rdata_o
);

  logic [WordBits-1:0] mem_q [NumWords];
  logic [WordBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/bba_word_scan.sv
// bba_word_scan: scan unit, finds the lowest clear bit of one bitmap word
// depends on bba_pkg
`default_nettype none

module bba_word_scan
  import bba_pkg::*;
#(
  parameter int NumBlocks = NUM_BLOCKS_DEF,
  parameter int WordBits  = WORD_BITS_DEF,
  localparam int BitW     = $clog2(WordBits)
) (
  input  wire logic [WordBits-1:0] word_i,
  input  wire logic                is_last_i,
  output logic                     found_o,
  output logic      [BitW-1:0]     idx_o,
  output logic      [WordBits-1:0] word_set_o
);

  localparam int NumWords  = (NumBlocks + WordBits - 1) / WordBits;
  localparam int LastValid = NumBlocks - (NumWords - 1) * WordBits;

  logic [WordBits-1:0] pad;
  logic [WordBits-1:0] eff;

  // bits past the last block in the final word count as used
  always_comb begin
    for (int j = 0; j < WordBits; j++) begin
      pad[j] = is_last_i && (j >= LastValid);
    end
  end

  assign eff     = word_i | pad;
  assign found_o = ~&eff;

  always_comb begin
    idx_o = '0;
    for (int j = WordBits - 1; j >= 0; j--) begin
      if (!eff[j]) begin
        idx_o = BitW'(j);
      end
    end
  end

  always_comb begin
    word_set_o        = word_i;
    word_set_o[idx_o] = 1'b1;
  end

endmodule

`default_nettype wire

### rtl/bba_seq.sv
// bba_seq: request sequencer, clearing pass, word scan, free check and output register
// depends on bba_pkg; drives bba_bitmap_mem and uses bba_word_scan results
`default_nettype none

module bba_seq
  import bba_pkg::*;
#(
  parameter int NumBlocks = NUM_BLOCKS_DEF,
  parameter int WordBits  = WORD_BITS_DEF,
  localparam int NumWords = (NumBlocks + WordBits - 1) / WordBits,
  localparam int WaW      = (NumWords > 1) ? $clog2(NumWords) : 1,
  localparam int BitW     = $clog2(WordBits)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_word_t            in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_word_t                out_word_o,
  output logic                     we_o,
  output logic      [WaW-1:0]      waddr_o,
  output logic      [WordBits-1:0] wdata_o,
  output logic      [WaW-1:0]      raddr_o,
  input  wire logic [WordBits-1:0] rdata_i,
  output logic                     is_last_o,
  input  wire logic                found_i,
  input  wire logic [BitW-1:0]     idx_i,
  input  wire logic [WordBits-1:0] word_set_i
);

  localparam int Recip    = (1 << RECIP_SH) / WordBits;

  localparam logic [WaW-1:0] LastWord = WaW'(NumWords - 1);

  seq_state_e state_q, state_d;
  logic [WaW-1:0]      ptr_q, ptr_d;
  logic                out_valid_q, out_valid_d;

  logic [NUM_W-1:0]    num_q, num_d;
  logic [NUM_W-1:0]    q0_q, q0_d;
  logic [BitW-1:0]     bit_q, bit_d;
  status_e             res_status_q, res_status_d;
  logic [NUM_W-1:0]    res_grant_q, res_grant_d;
  out_word_t           out_q, out_d;

  logic                in_fire;
  logic                out_free;
  logic [31:0]         div_prod;
  logic [31:0]         div_quot;
  logic [31:0]         back_prod;
  logic [NUM_W:0]      rem;
  logic [NUM_W:0]      rem_adj;
  logic [NUM_W-1:0]    widx;
  logic [31:0]         blk;
  logic                bad_num;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign is_last_o   = (ptr_q == LastWord);

  // block number to word and bit: reciprocal multiply, then one correction step
  assign div_prod  = 32'(num_q) * 32'(Recip);
  assign div_quot  = div_prod >> RECIP_SH;
  assign back_prod = 32'(q0_q) * 32'(WordBits);
  assign rem       = {1'b0, num_q} - {1'b0, back_prod[NUM_W-1:0]};
  assign rem_adj   = rem - (NUM_W+1)'(WordBits);

  always_comb begin
    if (rem >= (NUM_W+1)'(WordBits)) begin
      widx  = q0_q + NUM_W'(1);
      bit_d = rem_adj[BitW-1:0];
    end else begin
      widx  = q0_q;
      bit_d = rem[BitW-1:0];
    end
  end

  assign blk     = 32'(ptr_q) * 32'(WordBits) + 32'(idx_i);
  assign bad_num = (in_word_i.block_number == '0) ||
                   (32'(in_word_i.block_number) >= 32'(NumBlocks));

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    num_d        = num_q;
    q0_d         = q0_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    we_o         = 1'b0;
    waddr_o      = ptr_q;
    wdata_o      = '0;
    raddr_o      = ptr_q;

    case (state_q)
      S_CLEAR: begin
        we_o       = 1'b1;
        wdata_o[0] = (ptr_q == '0);
        ptr_d      = ptr_q + WaW'(1);
        if (ptr_q == LastWord) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        raddr_o = '0;
        if (in_fire) begin
          if (in_word_i.kind == KIND_FREE) begin
            if (bad_num) begin
              res_status_d = ST_RANGE;
              res_grant_d  = '0;
              state_d      = S_DONE;
            end else begin
              num_d   = in_word_i.block_number;
              state_d = S_FREE_DIV;
            end
          end else begin
            ptr_d   = '0;
            state_d = S_ALOC_SCAN;
          end
        end
      end
      S_ALOC_SCAN: begin
        raddr_o = ptr_q + WaW'(1);
        if (found_i) begin
          we_o         = 1'b1;
          wdata_o      = word_set_i;
          res_status_d = ST_OK;
          res_grant_d  = blk[NUM_W-1:0];
          state_d      = S_DONE;
        end else if (ptr_q == LastWord) begin
          res_status_d = ST_FULL;
          res_grant_d  = '0;
          state_d      = S_DONE;
        end else begin
          ptr_d = ptr_q + WaW'(1);
        end
      end
      S_FREE_DIV: begin
        q0_d    = div_quot[NUM_W-1:0];
        state_d = S_FREE_RD;
      end
      S_FREE_RD: begin
        raddr_o = widx[WaW-1:0];
        ptr_d   = widx[WaW-1:0];
        state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        res_grant_d = '0;
        if (!rdata_i[bit_q]) begin
          res_status_d = ST_NOT_USED;
        end else begin
          we_o           = 1'b1;
          wdata_o        = rdata_i;
          wdata_o[bit_q] = 1'b0;
          res_status_d   = ST_OK;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_d.status        = res_status_q;
          out_d.granted_block = res_grant_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q        <= num_d;
    q0_q         <= q0_d;
    if (state_q == S_FREE_RD) begin
      bit_q <= bit_d;
    end
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    out_q        <= out_d;
  end

endmodule

`default_nettype wire

### rtl/bitmap_block_allocator.sv
// allocate: scans the bitmap words from word 0 up to the first word with a free bit,
// or through every word when full; free: divide, read and check states; a free with a
// bad block number goes straight to the result. throughput: one request at a time; the
// allocate scan reads one bitmap word per cycle through the bitmap read port (32 words by default)
// reset: control clears at once, then a clearing pass writes every bitmap word in turn
// (block 0 used) while in_stall_o stays high
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NumBlocks = NUM_BLOCKS_DEF,
  parameter int WordBits  = WORD_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  // bitmap geometry: block n lives in bit n mod WordBits of word n / WordBits
  localparam int NumWords = (NumBlocks + WordBits - 1) / WordBits;
  localparam int WaW      = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int BitW     = $clog2(WordBits);

  // bitmap memory port
  logic                we;
  logic [WaW-1:0]      waddr;
  logic [WordBits-1:0] wdata;
  logic [WaW-1:0]      raddr;
  logic [WordBits-1:0] rdata;

  // scan unit
  logic                is_last;
  logic                found;
  logic [BitW-1:0]     idx;
  logic [WordBits-1:0] word_set;

  // sequencer: clearing pass, allocate scan, free check, and the output register
  // that lets the next request in while a result still waits downstream
  bba_seq #(
    .NumBlocks (NumBlocks),
    .WordBits  (WordBits)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .is_last_o   (is_last),
    .found_i     (found),
    .idx_i       (idx),
    .word_set_i  (word_set)
  );

  // one word per cycle comes out of the registered read port into the scan unit
  bba_bitmap_mem #(
    .NumBlocks (NumBlocks),
    .WordBits  (WordBits)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // lowest clear bit of the word under scan; padding bits of the last word read as used
  bba_word_scan #(
    .NumBlocks (NumBlocks),
    .WordBits  (WordBits)
  ) u_scan (
    .word_i     (rdata),
    .is_last_i  (is_last),
    .found_o    (found),
    .idx_o      (idx),
    .word_set_o (word_set)
  );

endmodule

`default_nettype wire

### rtl/bba_checker.sv
// bba_checker: port-level assertions for the bitmap block allocator
// depends on bba_pkg; bound to bitmap_block_allocator
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  // one request at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a request was in flight");

  // a result never shows up in the cycle right after a request is taken, unless a stalled one is still held
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !(out_valid_o && out_stall_i) |=> !out_valid_o)
    else $error("result appeared too early");

  // only a successful allocate carries a block number
  a_grant_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != ST_OK) |-> (out_word_o.granted_block == '0))
    else $error("nonzero block number with error status");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
